### rtl/set_assoc_cache_tag_store_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag store
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// check held off while reset is high
`define SACTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check active in every cycle, reset included
`define SACTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SACTS_ASSERT(lbl, clk, rst, prop, msg)
`define SACTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/sacts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag store package
// Shared constants, register and action codes, and item types.
// ----------------------------------------------------------------------------
package sacts_pkg;

  // geometry
  localparam int MAX_SETS     = 256;
  localparam int SET_W        = $clog2(MAX_SETS);
  localparam int MAX_WAYS_DEF = 4;
  localparam int AGE_BITS_DEF = 32;
  localparam int TAG_W        = 30;
  localparam int ADDR_W       = 32;

  // address cut limits
  localparam logic [3:0] OB_MIN = 4'd2;
  localparam logic [3:0] OB_MAX = 4'd12;
  localparam logic [3:0] SB_MAX = 4'd12;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED   = 2'd2;

  localparam logic [3:0] OFFSET_BITS_RST = 4'd4;
  localparam logic [3:0] SET_BITS_RST    = 4'd8;
  localparam logic [2:0] WAYS_USED_RST   = 3'd1;

  // access kinds
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [1:0]        action;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       evicted;
    logic       copy_back;
    logic [1:0] way_used;
    logic       instruction_stream;
  } out_item_t;

endpackage

### rtl/sacts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sacts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/sacts_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag store set update
// Hit search, fill and victim choice, aging and dirty update for one set row.
// ----------------------------------------------------------------------------
module sacts_lookup #(
  parameter int MAX_WAYS = sacts_pkg::MAX_WAYS_DEF,
  parameter int AGE_BITS = sacts_pkg::AGE_BITS_DEF
) (
  input  logic [MAX_WAYS*(AGE_BITS+sacts_pkg::TAG_W+2)-1:0] row_in,
  input  logic [sacts_pkg::TAG_W-1:0]                       tag,
  input  logic [1:0]                                        action,
  input  logic [2:0]                                        ways_cfg,
  output logic [MAX_WAYS*(AGE_BITS+sacts_pkg::TAG_W+2)-1:0] row_out,
  output sacts_pkg::out_item_t                              result
);

  localparam int TAG_W = sacts_pkg::TAG_W;
  localparam int WAY_W = AGE_BITS + TAG_W + 2;
  localparam int WIX   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NP    = 1 << $clog2(MAX_WAYS);
  localparam int TAG_LO = AGE_BITS;
  localparam int DIRTY_B = AGE_BITS + TAG_W;
  localparam int VALID_B = AGE_BITS + TAG_W + 1;

  logic [4:0]          ways_eff;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] invalid;
  logic [WIX-1:0]      hit_way;
  logic [WIX-1:0]      inv_way;
  logic [WIX-1:0]      vic_way;
  logic [WIX-1:0]      way;
  logic [WIX+1:0]      way_wide;
  logic                hit;
  logic                any_inv;
  logic                evict;
  logic                vic_dirty;
  logic                is_write;
  logic [AGE_BITS-1:0] k_age [NP];
  logic [WIX-1:0]      k_idx [NP];

  assign is_write = (action == sacts_pkg::ACT_WRITE);

  // associativity in use, clamped to 1..MAX_WAYS
  always_comb begin
    if (ways_cfg == 3'd0) begin
      ways_eff = 5'd1;
    end else if ({2'b00, ways_cfg} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {2'b00, ways_cfg};
    end
  end

  // per-way tag match and free-way flags
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = 5'(w) < ways_eff;
      match[w]   = in_use[w] && row_in[w*WAY_W + VALID_B]
                   && (row_in[w*WAY_W + TAG_LO +: TAG_W] == tag);
      invalid[w] = in_use[w] && !row_in[w*WAY_W + VALID_B];
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WIX'(w);
      end
      if (invalid[w]) begin
        inv_way = WIX'(w);
      end
    end
  end

  assign hit     = |match;
  assign any_inv = |invalid;

  // victim: smallest age, lower way wins ties, reduction tree
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      k_idx[i] = WIX'(i);
      if (i < MAX_WAYS && 5'(i) < ways_eff) begin
        k_age[i] = row_in[i*WAY_W +: AGE_BITS];
      end else begin
        k_age[i] = '1;
      end
    end
    for (int s = 1; s < NP; s = s * 2) begin
      for (int i = 0; i + s < NP; i = i + 2 * s) begin
        if (k_age[i+s] < k_age[i]) begin
          k_age[i] = k_age[i+s];
          k_idx[i] = k_idx[i+s];
        end
      end
    end
    vic_way = k_idx[0];
  end

  // dirty bit of the victim
  always_comb begin
    vic_dirty = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WIX'(w) == vic_way) begin
        vic_dirty = row_in[w*WAY_W + DIRTY_B];
      end
    end
  end

  assign evict = !hit && !any_inv;

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = vic_way;
    end
  end

  // updated row: fill or dirty the touched way, age every way in use
  always_comb begin
    row_out = row_in;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WIX'(w) == way) begin
        row_out[w*WAY_W + VALID_B] = 1'b1;
        if (hit) begin
          row_out[w*WAY_W + DIRTY_B] = row_in[w*WAY_W + DIRTY_B] | is_write;
        end else begin
          row_out[w*WAY_W + DIRTY_B]          = is_write;
          row_out[w*WAY_W + TAG_LO +: TAG_W]  = tag;
        end
      end
      if (in_use[w]) begin
        row_out[w*WAY_W +: AGE_BITS] = row_in[w*WAY_W +: AGE_BITS] >> 1;
        if (WIX'(w) == way) begin
          row_out[w*WAY_W + AGE_BITS - 1] = 1'b1;
        end
      end
    end
  end

  // result item
  assign way_wide = {2'b00, way};
  always_comb begin
    result.hit                = hit;
    result.evicted            = evict;
    result.copy_back          = evict && vic_dirty;
    result.way_used           = way_wide[1:0];
    result.instruction_stream = (action == sacts_pkg::ACT_FETCH);
  end

endmodule

### rtl/set_assoc_cache_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache tag store
// Tag lookup, fill, aging replacement and dirty tracking for a write-back cache.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one access item (address, action) per accepted edge, taken
//   when req_valid is high and req_stall is low.
//   resp channel: one result item per access (hit, evicted, copy_back,
//   way_used, instruction_stream), in access order, held while resp_stall.
//   cfg channel: offset_bits, set_bits, ways_used writes; cfg_ready is always
//   high. Write only while no access is in flight.
// Timing
//   An access accepted at an edge is loaded into the lookup stage registers
//   as the tag RAM reads its set row; it is resolved there, and when the
//   stage advances, its row is written back and its result loaded on resp.
//   One access per cycle is sustained while resp_stall is low: the tag RAM
//   has one read and one write port, and a row being written back is
//   forwarded to an access of the same set that follows directly.
// Reset
//   rst clears the per-set valid flags at once, so all lines read as empty;
//   there is no clearing pass. Registers return to 4, 8 and 1.
// Stall
//   While resp_stall holds a finished result, one more access may be taken
//   and waits in the lookup stage; after that req_stall rises.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store #(
  parameter int MAX_WAYS = sacts_pkg::MAX_WAYS_DEF,
  parameter int AGE_BITS = sacts_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  sacts_pkg::in_item_t                 req,
  output logic                                resp_valid,
  input  logic                                resp_stall,
  output sacts_pkg::out_item_t                resp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sacts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacts_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "set_assoc_cache_tag_store_defines.svh"

  localparam int SET_W = sacts_pkg::SET_W;
  localparam int TAG_W = sacts_pkg::TAG_W;
  localparam int ROW_W = MAX_WAYS * (AGE_BITS + TAG_W + 2);

  // configuration registers
  logic [3:0] offset_bits;
  logic [3:0] set_bits;
  logic [2:0] ways_used;

  // address cut
  logic [3:0]         ob;
  logic [3:0]         sb;
  logic [4:0]         tag_shift;
  logic [31:0]        set_shifted;
  logic [31:0]        tag_shifted;
  logic [12:0]        set_mask;
  logic [SET_W-1:0]   req_set;
  logic [TAG_W-1:0]   req_tag;

  // lookup stage
  logic               l_valid;
  logic [SET_W-1:0]   l_set;
  logic [TAG_W-1:0]   l_tag;
  logic [1:0]         l_action;
  logic               l_fwd;
  logic [ROW_W-1:0]   l_fwd_row;
  logic               l_row_vld;
  logic               l_adv;
  logic               req_acc;

  logic [sacts_pkg::MAX_SETS-1:0] row_vld;
  logic [ROW_W-1:0]   rd_row;
  logic [ROW_W-1:0]   cur_row;
  logic [ROW_W-1:0]   new_row;
  sacts_pkg::out_item_t result;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sacts_pkg::OFFSET_BITS_RST;
      set_bits    <= sacts_pkg::SET_BITS_RST;
      ways_used   <= sacts_pkg::WAYS_USED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sacts_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        sacts_pkg::REG_SET_BITS:    set_bits    <= cfg_data;
        sacts_pkg::REG_WAYS_USED:   ways_used   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // saturate the cut widths
  always_comb begin
    if (offset_bits < sacts_pkg::OB_MIN) begin
      ob = sacts_pkg::OB_MIN;
    end else if (offset_bits > sacts_pkg::OB_MAX) begin
      ob = sacts_pkg::OB_MAX;
    end else begin
      ob = offset_bits;
    end
    if (set_bits > sacts_pkg::SB_MAX) begin
      sb = sacts_pkg::SB_MAX;
    end else begin
      sb = set_bits;
    end
  end

  // set index and tag of the incoming access
  assign tag_shift   = {1'b0, ob} + {1'b0, sb};
  assign set_shifted = req.address >> ob;
  assign tag_shifted = req.address >> tag_shift;
  assign set_mask    = (13'd1 << sb) - 13'd1;
  assign req_set     = set_shifted[SET_W-1:0] & set_mask[SET_W-1:0];
  assign req_tag     = tag_shifted[TAG_W-1:0];

  // handshake
  assign l_adv     = l_valid && (!resp_valid || !resp_stall);
  assign req_stall = l_valid && !l_adv;
  assign req_acc   = req_valid && !req_stall;

  // lookup stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (req_acc) begin
      l_valid <= 1'b1;
    end else if (l_adv) begin
      l_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      l_set     <= req_set;
      l_tag     <= req_tag;
      l_action  <= req.action;
      l_fwd     <= l_adv && (req_set == l_set);
      l_fwd_row <= new_row;
      l_row_vld <= row_vld[req_set];
    end
  end

  // per-set valid flags, an unwritten row reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (l_adv) begin
      row_vld[l_set] <= 1'b1;
    end
  end

  sacts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (sacts_pkg::MAX_SETS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (l_adv),
    .wr_addr (l_set),
    .wr_data (new_row),
    .rd_en   (req_acc),
    .rd_addr (req_set),
    .rd_data (rd_row)
  );

  // row source: forwarded write-back, stored row or empty
  always_comb begin
    if (l_fwd) begin
      cur_row = l_fwd_row;
    end else if (l_row_vld) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end
  end

  sacts_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .AGE_BITS (AGE_BITS)
  ) u_lookup (
    .row_in   (cur_row),
    .tag      (l_tag),
    .action   (l_action),
    .ways_cfg (ways_used),
    .row_out  (new_row),
    .result   (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (l_adv) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (l_adv) begin
      resp <= result;
    end
  end

  // checks
  `SACTS_ASSERT(a_hit_no_evict, clk, rst,
    resp_valid |-> !(resp.hit && resp.evicted), "hit reported together with eviction")
  `SACTS_ASSERT(a_copy_back_evict, clk, rst,
    resp_valid && resp.copy_back |-> resp.evicted, "copy-back without eviction")
  `SACTS_ASSERT(a_fwd_after_wb, clk, rst,
    req_acc && !l_adv |=> !l_fwd, "row forwarded without a write-back")
  `SACTS_ASSERT(a_row_marked, clk, rst,
    !$past(rst) && $past(l_adv) |-> row_vld[$past(l_set)], "written set not marked valid")
  `SACTS_ASSERT_ALWAYS(a_reset_idle, clk,
    $past(rst) |-> !l_valid && !resp_valid, "pipeline busy right after reset")

endmodule

### bench/tb_set_assoc_cache_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the set-associative cache tag store
// Sends address/action items through a queue-fed driver and predicts each
// result with a behavioral copy of the tag store: valid, dirty, tag and age
// per set and way, with its own copy of the address-cut registers. A clocked
// monitor compares every result item with the oldest prediction. The run
// steps through several register settings, saturated values included, with
// random gaps on both channels and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_store;

  localparam int NUM_WAYS = sacts_pkg::MAX_WAYS_DEF;
  localparam int NUM_SETS = sacts_pkg::MAX_SETS;
  localparam int TAG_W = sacts_pkg::TAG_W;
  localparam int AGE_W = sacts_pkg::AGE_BITS_DEF;
  localparam int IDX_W = sacts_pkg::CFG_IDX_W;
  localparam int DATA_W = sacts_pkg::CFG_DATA_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 120;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [1:0] ACT_UNDEF = 2'd3;
  localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  sacts_pkg::in_item_t req = '0;
  logic resp_valid;
  logic resp_stall = 1'b0;
  sacts_pkg::out_item_t resp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // predicted tag store contents and register copy
  bit tag_valid [NUM_SETS][NUM_WAYS];
  bit tag_dirty [NUM_SETS][NUM_WAYS];
  logic [TAG_W-1:0] tag_value [NUM_SETS][NUM_WAYS];
  logic [AGE_W-1:0] way_age [NUM_SETS][NUM_WAYS];
  logic [3:0] cut_offset = sacts_pkg::OFFSET_BITS_RST;
  logic [3:0] cut_set = sacts_pkg::SET_BITS_RST;
  logic [2:0] way_count = sacts_pkg::WAYS_USED_RST;

  sacts_pkg::in_item_t pending_accesses[$];
  sacts_pkg::out_item_t expected_results[$];
  logic req_fire = 1'b0;
  int failures = 0;
  int unsigned cycle_count = 0;

  // idling controls
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int holds_asked = 0;
  int holds_given = 0;

  set_assoc_cache_tag_store dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp(resp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  // lookup, fill or evict, then age the set; returns the predicted result
  function automatic sacts_pkg::out_item_t cache_access(sacts_pkg::in_item_t item);
    int unsigned ob, sb, nways, set_idx, way;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] best;
    bit found, is_hit, is_evict, is_copy, is_write;
    sacts_pkg::out_item_t r;
    ob = cut_offset;
    if (ob < sacts_pkg::OB_MIN) ob = sacts_pkg::OB_MIN;
    if (ob > sacts_pkg::OB_MAX) ob = sacts_pkg::OB_MAX;
    sb = cut_set;
    if (sb > sacts_pkg::SB_MAX) sb = sacts_pkg::SB_MAX;
    nways = way_count;
    if (nways < 1) nways = 1;
    if (nways > NUM_WAYS) nways = NUM_WAYS;
    set_idx = ((item.address >> ob) & ((32'd1 << sb) - 32'd1)) % NUM_SETS;
    tag = TAG_W'(item.address >> (ob + sb));
    is_write = (item.action == sacts_pkg::ACT_WRITE);
    found = 1'b0;
    is_hit = 1'b0;
    is_evict = 1'b0;
    is_copy = 1'b0;
    way = 0;
    for (int w = 0; w < nways && !found; w++) begin
      if (tag_valid[set_idx][w] && tag_value[set_idx][w] == tag) begin
        way = w;
        found = 1'b1;
        is_hit = 1'b1;
      end
    end
    if (is_hit) begin
      if (is_write) tag_dirty[set_idx][way] = 1'b1;
    end else begin
      for (int w = 0; w < nways && !found; w++) begin
        if (!tag_valid[set_idx][w]) begin
          way = w;
          found = 1'b1;
        end
      end
      // no free way: oldest age loses, lowest way on a tie
      if (!found) begin
        best = way_age[set_idx][0];
        way = 0;
        for (int w = 1; w < nways; w++) begin
          if (way_age[set_idx][w] < best) begin
            best = way_age[set_idx][w];
            way = w;
          end
        end
        is_evict = 1'b1;
        is_copy = tag_dirty[set_idx][way];
      end
      tag_valid[set_idx][way] = 1'b1;
      tag_value[set_idx][way] = tag;
      tag_dirty[set_idx][way] = is_write;
    end
    for (int w = 0; w < nways; w++) begin
      way_age[set_idx][w] = way_age[set_idx][w] >> 1;
      if (w == way) way_age[set_idx][w] = way_age[set_idx][w] | AGE_TOP;
    end
    r.hit = is_hit;
    r.evicted = is_evict;
    r.copy_back = is_copy;
    r.way_used = way[1:0];
    r.instruction_stream = (item.action == sacts_pkg::ACT_FETCH);
    return r;
  endfunction

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // driver: next item goes out at the falling edge after acceptance or a gap
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (pending_accesses.size() != 0) begin
        req <= pending_accesses.pop_front();
        req_valid <= 1'b1;
        send_gap = (send_idle && $urandom_range(0, 1) == 1) ? idle_len() : 0;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      resp_stall <= 1'b0;
    end else begin
      if (holds_asked != holds_given) begin
        stall_left = LONG_HOLD;
        holds_given++;
      end else if (stall_left == 0 && recv_idle && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        resp_stall <= 1'b1;
        stall_left--;
      end else begin
        resp_stall <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict the item accepted at this edge
  always @(posedge clk) begin : monitor
    sacts_pkg::out_item_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (resp_valid && !resp_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no access outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, resp.hit);
          check_field("evicted", want.evicted, resp.evicted);
          check_field("copy_back", want.copy_back, resp.copy_back);
          check_field("way_used", want.way_used, resp.way_used);
          check_field("instruction_stream", want.instruction_stream,
                      resp.instruction_stream);
        end
      end
      if (req_valid && !req_stall) expected_results.push_back(cache_access(req));
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_set_assoc_cache_tag_store: done, errors");
      $finish;
    end
  end

  task automatic push_access(logic [sacts_pkg::ADDR_W-1:0] addr, logic [1:0] act);
    sacts_pkg::in_item_t item;
    item.address = addr;
    item.action = act;
    pending_accesses.push_back(item);
  endtask

  // wait until every item is in and every result is out, then settle
  task automatic drain();
    while (pending_accesses.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sacts_pkg::REG_OFFSET_BITS: cut_offset = val;
      sacts_pkg::REG_SET_BITS: cut_set = val;
      sacts_pkg::REG_WAYS_USED: way_count = val[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_cut(logic [3:0] ob, logic [3:0] sb, logic [3:0] ways);
    drain();
    write_reg(sacts_pkg::REG_OFFSET_BITS, ob);
    write_reg(sacts_pkg::REG_SET_BITS, sb);
    write_reg(sacts_pkg::REG_WAYS_USED, ways);
    cfg_valid <= 1'b0;
  endtask

  // random phase: at most four pooled sets and two more tags than ways, so lines collide
  task automatic run_phase(logic [3:0] ob, logic [3:0] sb, logic [3:0] ways,
                           bit s_idle, bit r_idle, bit hold, int count);
    int unsigned ob_e, sb_e, nw, pick;
    logic [31:0] set_pool [4];
    logic [31:0] tag_base, tag_pick, set_mask, addr;
    logic [1:0] act;
    set_cut(ob, sb, ways);
    send_idle = s_idle;
    recv_idle = r_idle;
    ob_e = (ob < sacts_pkg::OB_MIN) ? sacts_pkg::OB_MIN :
           (ob > sacts_pkg::OB_MAX) ? sacts_pkg::OB_MAX : ob;
    sb_e = (sb > sacts_pkg::SB_MAX) ? sacts_pkg::SB_MAX : sb;
    nw = ways[2:0];
    if (nw < 1) nw = 1;
    if (nw > NUM_WAYS) nw = NUM_WAYS;
    set_mask = (32'd1 << sb_e) - 32'd1;
    tag_base = $urandom();
    for (int k = 0; k < 4; k++) set_pool[k] = $urandom();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        addr = $urandom();
      end else begin
        tag_pick = tag_base + $urandom_range(0, nw + 1);
        addr = (tag_pick << (ob_e + sb_e))
             | ((set_pool[$urandom_range(0, 3)] & set_mask) << ob_e)
             | ($urandom() & ((32'd1 << ob_e) - 32'd1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) act = sacts_pkg::ACT_READ;
      else if (pick < 75) act = sacts_pkg::ACT_WRITE;
      else if (pick < 95) act = sacts_pkg::ACT_FETCH;
      else act = ACT_UNDEF;
      push_access(addr, act);
    end
    if (hold) holds_asked++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset cut, one way: fill, dirty hit, conflict with copy-back, top set
    push_access(32'h0000_0000, sacts_pkg::ACT_READ);
    push_access(32'h0000_0008, sacts_pkg::ACT_WRITE);
    push_access(32'h0000_1000, sacts_pkg::ACT_READ);
    push_access(32'hFFFF_FFFF, sacts_pkg::ACT_FETCH);
    push_access(32'hFFFF_FFF0, ACT_UNDEF);
    push_access(32'hAAAA_5550, sacts_pkg::ACT_WRITE);
    push_access(32'h5555_AAA0, sacts_pkg::ACT_READ);
    push_access(32'h5555_A550, sacts_pkg::ACT_READ);

    // single set, four ways: fill every way, hit, then evict by age
    set_cut(4'd2, 4'd0, 4'd4);
    @(negedge clk);
    write_reg(REG_SPARE, 4'hF);
    cfg_valid <= 1'b0;
    push_access(32'h0000_0000, sacts_pkg::ACT_READ);
    push_access(32'h0000_0004, sacts_pkg::ACT_WRITE);
    push_access(32'h0000_0008, sacts_pkg::ACT_FETCH);
    push_access(32'h0000_000C, ACT_UNDEF);
    push_access(32'h0000_0004, sacts_pkg::ACT_READ);
    push_access(32'h0000_0010, sacts_pkg::ACT_READ);
    push_access(32'h0000_0014, sacts_pkg::ACT_WRITE);
    push_access(32'h0000_0018, sacts_pkg::ACT_READ);
    push_access(32'h0000_001C, sacts_pkg::ACT_WRITE);

    run_phase(4'd3, 4'd1, 4'd3, 1'b1, 1'b1, 1'b0, 80);
    run_phase(4'd12, 4'd8, 4'd2, 1'b0, 1'b0, 1'b1, 80);
    run_phase(4'd0, 4'd15, 4'd7, 1'b1, 1'b1, 1'b0, 80);
    run_phase(4'd15, 4'd12, 4'd0, 1'b1, 1'b1, 1'b0, 80);
    run_phase(4'd5, 4'd4, 4'd4, 1'b1, 1'b0, 1'b0, 80);
    run_phase(4'd2, 4'd2, 4'd13, 1'b0, 1'b1, 1'b0, 80);
    run_phase(4'd7, 4'd3, 4'd8, 1'b1, 1'b1, 1'b0, 80);
    run_phase(4'd4, 4'd8, 4'd4, 1'b1, 1'b1, 1'b1, 90);
    drain();

    if (failures == 0) begin
      $display("tb_set_assoc_cache_tag_store: done, clean");
    end else begin
      $display("tb_set_assoc_cache_tag_store: done, errors");
    end
    $finish;
  end

endmodule
